/* design/gcs_pkg.sv */
// Shared constants, types and helpers for the growable capacity stack.
`default_nettype none

package gcs_pkg;

	localparam int MAX_DEPTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_DEPTH);
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int CAP_W     = 11;
	localparam int WORD_W    = 32;

	// Result fields: ok, popped_value, top_value, is_empty, is_full, capacity_now
	localparam int RES_W     = 1 + WORD_W + WORD_W + 1 + 1 + CAP_W;
	localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] INIT_CAP_DEFAULT  = CAP_W'(10);
	localparam logic [CAP_W-1:0] GROW_STEP_DEFAULT = CAP_W'(16);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic {
		REG_INIT_CAP  = 1'b0,
		REG_GROW_STEP = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP_RD
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// Zero maps to the default, values above the store depth clamp to it.
	function automatic logic [CNT_W-1:0] eff_initial(input logic [CAP_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(INIT_CAP_DEFAULT);
		end else if (int'(v) > MAX_DEPTH) begin
			r = CNT_W'(MAX_DEPTH);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/gcs_ram.sv */
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module gcs_ram (
	input  wire logic                          clk,
	input  wire gcs_pkg::ram_wr_t              wr,
	input  wire gcs_pkg::ram_rd_t              rd,
	output logic [gcs_pkg::WORD_W-1:0]         rdata
);

	logic [gcs_pkg::WORD_W-1:0] mem [gcs_pkg::MAX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

/* design/growable_capacity_stack.sv */
// Top level of the growable capacity LIFO stack.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tuser func, s_tdata push_value
//  m_*     | out       | m_tvalid / m_tready | m_tdata ok..capacity_now (80 bits)
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A push writes the entry and keeps the new word in the top register.
// A pop that leaves at least one word also reads the new top entry through the
// registered memory read port, and returns its result from the ST_POP_RD state.
// Other pops and all failed operations return their result straight from idle.
// Reset clears the count and loads the default capacity; the store is not cleared.
// The result register lets a new transfer in while the previous result is taken.
`default_nettype none

module growable_capacity_stack (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [gcs_pkg::WORD_W-1:0]      s_tdata,  // [31:0] push_value
	input  wire logic                            s_tuser,  // [0] func
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] ok, [32:1] popped_value, [64:33] top_value, [65] is_empty,
	// [66] is_full, [77:67] capacity_now, [79:78] zero
	output logic [gcs_pkg::RES_PAD_W-1:0]        m_tdata,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic                            cfg_index,
	input  wire logic [gcs_pkg::CAP_W-1:0]       cfg_data
);

	localparam int CNT_W  = gcs_pkg::CNT_W;
	localparam int WORD_W = gcs_pkg::WORD_W;

	gcs_pkg::state_t            state_q, state_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [CNT_W-1:0]           cap_q, cap_d;
	logic [gcs_pkg::CAP_W-1:0]  step_q;
	logic [WORD_W-1:0]          top_q, top_d;
	logic [WORD_W-1:0]          hold_q, hold_d;
	logic                       out_valid_q;
	logic [gcs_pkg::RES_PAD_W-1:0] out_data_q;

	gcs_pkg::ram_wr_t           ram_wr;
	gcs_pkg::ram_rd_t           ram_rd;
	logic [WORD_W-1:0]          ram_rdata;

	logic                       in_fire, cfg_fire, load_out;
	logic                       can_grow, has_room;
	logic [CNT_W:0]             grow_sum;
	logic [CNT_W-1:0]           grown_cap;
	logic [CNT_W-1:0]           cnt_m2;
	logic                       res_ok;
	logic [WORD_W-1:0]          res_popped, res_top;

	gcs_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (ram_rdata)
	);

	// Accept only from idle, and only when the result slot is free or drains now.
	assign s_tready  = (state_q == gcs_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign cfg_ready = (state_q == gcs_pkg::ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Growth target, clamped to the store depth.
	assign grow_sum  = {1'b0, cap_q} + (CNT_W + 1)'(step_q);
	assign grown_cap = (int'(grow_sum) > gcs_pkg::MAX_DEPTH) ?
		CNT_W'(gcs_pkg::MAX_DEPTH) : grow_sum[CNT_W-1:0];
	assign can_grow  = (int'(cap_q) < gcs_pkg::MAX_DEPTH) && (step_q != '0);
	assign has_room  = (count_q < cap_q);
	assign cnt_m2    = count_q - CNT_W'(2);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		cap_d      = cap_q;
		top_d      = top_q;
		hold_d     = hold_q;
		ram_wr     = '0;
		ram_rd     = '0;
		load_out   = 1'b0;
		res_ok     = 1'b0;
		res_popped = '0;
		res_top    = '1;

		case (state_q)
			gcs_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (s_tuser == gcs_pkg::OP_PUSH) begin
						load_out = 1'b1;
						if (has_room || can_grow) begin
							if (!has_room) begin
								cap_d = grown_cap;
							end
							ram_wr.en   = 1'b1;
							ram_wr.addr = count_q[gcs_pkg::ADDR_W-1:0];
							ram_wr.data = s_tdata;
							count_d     = count_q + CNT_W'(1);
							top_d       = s_tdata;
							res_ok      = 1'b1;
							res_top     = s_tdata;
						end else begin
							// failed push: the stack is full, so it is not empty
							res_top = top_q;
						end
					end else begin
						if (count_q == '0) begin
							load_out = 1'b1;
						end else begin
							count_d    = count_q - CNT_W'(1);
							res_ok     = 1'b1;
							res_popped = top_q;
							if (count_q == CNT_W'(1)) begin
								load_out = 1'b1;
							end else begin
								// fetch the entry below the old top
								ram_rd.en   = 1'b1;
								ram_rd.addr = cnt_m2[gcs_pkg::ADDR_W-1:0];
								hold_d      = top_q;
								state_d     = gcs_pkg::ST_POP_RD;
							end
						end
					end
				end
			end
			gcs_pkg::ST_POP_RD: begin
				top_d      = ram_rdata;
				load_out   = 1'b1;
				res_ok     = 1'b1;
				res_popped = hold_q;
				res_top    = ram_rdata;
				state_d    = gcs_pkg::ST_IDLE;
			end
			default: begin
				state_d = gcs_pkg::ST_IDLE;
			end
		endcase

		// initial capacity write empties the stack
		if (cfg_fire && (cfg_index == gcs_pkg::REG_INIT_CAP)) begin
			count_d = '0;
			cap_d   = gcs_pkg::eff_initial(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= gcs_pkg::eff_initial(gcs_pkg::INIT_CAP_DEFAULT);
			step_q  <= gcs_pkg::GROW_STEP_DEFAULT;
		end else begin
			count_q <= count_d;
			cap_q   <= cap_d;
			if (cfg_fire && (cfg_index == gcs_pkg::REG_GROW_STEP)) begin
				step_q <= cfg_data;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		top_q  <= top_d;
		hold_q <= hold_d;
		if (load_out) begin
			out_data_q <= gcs_pkg::RES_PAD_W'({
				gcs_pkg::CAP_W'(cap_d),
				(count_d == cap_d),
				(count_d == '0),
				res_top,
				res_popped,
				res_ok
			});
		end
	end

	// result slot: fill on a finished item, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
